// ===== rtl/jsr_pkg.sv =====
// Package: shared widths, codes and types of the Jacobi stencil residual block.
package jsr_pkg;

  // Field widths of the channels and the configuration port
  localparam int SAMPLE_W  = 32;
  localparam int POS_W     = 10;
  localparam int RES_W     = 63;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  // Reset value of both geometry registers
  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 11'd1024;

  // Largest residual value
  localparam logic [RES_W-1:0] RES_SAT = {RES_W{1'b1}};

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [RES_W-1:0]           res_t;
  typedef logic [CFG_W-1:0]           cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  // One classified point: an interior update or the end of the frame
  typedef struct packed {
    logic    done;
    sample_t left;
    sample_t right;
    sample_t top;
    sample_t bottom;
    sample_t center;
    pos_t    row;
    pos_t    col;
  } point_t;

  // Queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic one_left;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/jsr_if.sv =====
// Interfaces: valid/ready channels for grid samples and for results.
interface jsr_in_if;
  logic              valid;
  logic              ready;
  jsr_pkg::sample_t  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface jsr_out_if;
  logic              valid;
  logic              ready;
  jsr_pkg::sample_t  relaxed_value;
  jsr_pkg::pos_t     point_row;
  jsr_pkg::pos_t     point_column;
  jsr_pkg::res_t     residual;
  logic              frame_done;

  modport source (output valid, output relaxed_value, output point_row,
                  output point_column, output residual, output frame_done,
                  input ready);
  modport sink   (input valid, input relaxed_value, input point_row,
                  input point_column, input residual, input frame_done,
                  output ready);
endinterface

// ===== rtl/jsr_queue.sv =====
// Module: short queue of classified points between the front and the back.
module jsr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jsr_pkg::point_t    push_item,
  input  logic               pop,
  output jsr_pkg::point_t    pop_item,
  output jsr_pkg::q_status_t status
);

  jsr_pkg::point_t                 entry_r [jsr_pkg::QDEPTH];
  logic [jsr_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [jsr_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [jsr_pkg::QCNT_W-1:0]      count_r;
  logic [jsr_pkg::QCNT_W-1:0]      count_nxt;

  // Store pushed points
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  assign pop_item        = entry_r[rd_ptr_r];
  assign status.full     = (count_r == jsr_pkg::QCNT_W'(jsr_pkg::QDEPTH));
  assign status.one_left = (count_r == jsr_pkg::QCNT_W'(jsr_pkg::QDEPTH - 1));
  assign status.empty    = (count_r == '0);

endmodule

// ===== rtl/jsr_front.sv =====
// Module: sample intake, grid position tracking, row stores and point classification.
module jsr_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  jsr_in_if.sink               in_ch,
  input  logic                 cfg_we,
  input  jsr_pkg::cfg_idx_t    cfg_index,
  input  jsr_pkg::cfg_data_t   cfg_wdata,
  input  jsr_pkg::q_status_t   q_st,
  output logic                 q_push,
  output jsr_pkg::point_t      q_item
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // Geometry registers
  jsr_pkg::cfg_data_t width_r;
  jsr_pkg::cfg_data_t height_r;
  logic               refetch_r;

  // Position of the next sample
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;

  // Row stores: older holds row r-2, newer holds row r-1
  jsr_pkg::sample_t older_mem [MAX_WIDTH];
  jsr_pkg::sample_t newer_mem [MAX_WIDTH];
  jsr_pkg::sample_t older_rd_r;
  jsr_pkg::sample_t newer_rd_r;
  jsr_pkg::sample_t held_left_r;

  // Staged point waiting for its right neighbor
  logic             s1_valid_r;
  jsr_pkg::point_t  s1_item_r;

  logic [CW:0]   w_eff;
  logic [RW:0]   h_eff;
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;
  logic [CW-1:0] col_eff;
  logic [CW-1:0] next_col;
  logic [CW-1:0] rd_addr;
  logic          is_last_col;
  logic          is_last_row;
  logic          interior;
  logic          frame_end;
  logic          accept;
  logic          rd_en;

  // Clamp geometry to the supported range
  always_comb begin
    if (width_r < jsr_pkg::CFG_W'(3)) begin
      w_eff = (CW+1)'(3);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(width_r);
    end
    if (height_r < jsr_pkg::CFG_W'(3)) begin
      h_eff = (RW+1)'(3);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(height_r);
    end
  end

  // Classify the current position
  always_comb begin
    last_col    = CW'(w_eff - 1'b1);
    last_row    = RW'(h_eff - 1'b1);
    col_eff     = (col_r > last_col) ? last_col : col_r;
    is_last_col = (col_eff == last_col);
    is_last_row = (row_r >= last_row);
    interior    = (row_r > RW'(1)) && (col_eff != '0) && (col_eff < last_col);
    frame_end   = is_last_col && is_last_row;
    next_col    = is_last_col ? '0 : col_eff + 1'b1;
  end

  assign in_ch.ready = !refetch_r && !q_st.full && !(q_st.one_left && s1_valid_r);
  assign accept      = in_ch.valid && in_ch.ready;

  // Prefetch the next column; after a geometry write reload the current one
  assign rd_en   = accept || refetch_r;
  assign rd_addr = refetch_r ? col_eff : next_col;

  always_ff @(posedge clk) begin
    if (accept) begin
      older_mem[col_eff] <= newer_rd_r;
      newer_mem[col_eff] <= in_ch.sample;
    end
    if (rd_en) begin
      older_rd_r <= older_mem[rd_addr];
      newer_rd_r <= newer_mem[rd_addr];
    end
  end

  // Hold geometry and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= jsr_pkg::CFG_DIM_RESET;
      height_r  <= jsr_pkg::CFG_DIM_RESET;
      refetch_r <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
    end else begin
      refetch_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          jsr_pkg::REG_GRID_WIDTH:  width_r  <= cfg_wdata;
          jsr_pkg::REG_GRID_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        col_r <= next_col;
        if (is_last_col) begin
          row_r <= is_last_row ? '0 : row_r + 1'b1;
        end
      end
    end
  end

  // Stage the point; drop border points that end nothing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept && (interior || frame_end);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_left_r      <= newer_rd_r;
      s1_item_r.done   <= frame_end;
      s1_item_r.left   <= held_left_r;
      s1_item_r.right  <= '0;
      s1_item_r.top    <= older_rd_r;
      s1_item_r.bottom <= in_ch.sample;
      s1_item_r.center <= newer_rd_r;
      s1_item_r.row    <= jsr_pkg::POS_W'(row_r - 1'b1);
      s1_item_r.col    <= jsr_pkg::POS_W'(col_eff);
    end
  end

  // Push with the right neighbor read during the accept cycle
  always_comb begin
    q_item       = s1_item_r;
    q_item.right = newer_rd_r;
  end
  assign q_push = s1_valid_r;

endmodule

// ===== rtl/jsr_back.sv =====
// Module: relaxation arithmetic, squared-update residual and result register.
module jsr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  jsr_pkg::q_status_t q_st,
  input  jsr_pkg::point_t    q_item,
  output logic               q_pop,
  jsr_out_if.source          out_ch
);

  logic en;

  // Stage 1: four-neighbor sum
  logic               v1_r;
  logic               done1_r;
  logic signed [33:0] sum1_r;
  jsr_pkg::sample_t   center1_r;
  jsr_pkg::pos_t      row1_r;
  jsr_pkg::pos_t      col1_r;

  // Stage 2: new value and update difference
  logic               v2_r;
  logic               done2_r;
  jsr_pkg::sample_t   nv2_r;
  logic signed [32:0] diff2_r;
  jsr_pkg::pos_t      row2_r;
  jsr_pkg::pos_t      col2_r;

  // Stage 3: squared update
  logic               v3_r;
  logic               done3_r;
  jsr_pkg::sample_t   nv3_r;
  logic [64:0]        sq3_r;
  jsr_pkg::pos_t      row3_r;
  jsr_pkg::pos_t      col3_r;

  logic signed [33:0] sum_nxt;
  logic signed [32:0] diff_nxt;
  logic signed [65:0] prod;
  jsr_pkg::res_t      sq_sat;
  logic [63:0]        acc_sum;
  jsr_pkg::res_t      acc_nxt;
  jsr_pkg::res_t      acc_r;

  // Result register
  logic               out_valid_r;
  jsr_pkg::sample_t   out_value_r;
  jsr_pkg::pos_t      out_row_r;
  jsr_pkg::pos_t      out_col_r;
  jsr_pkg::res_t      out_res_r;
  logic               out_done_r;

  // Advance the whole pipe unless the result register is stuck
  assign en    = !out_valid_r || out_ch.ready;
  assign q_pop = en && !q_st.empty;

  assign sum_nxt = 34'(q_item.left) + 34'(q_item.right) + 34'(q_item.top)
                 + 34'(q_item.bottom);
  assign diff_nxt = 33'(jsr_pkg::sample_t'(sum1_r[33:2])) - 33'(center1_r);
  assign prod     = diff2_r * diff2_r;

  // Clamp the square, then add with saturation
  always_comb begin
    sq_sat  = (sq3_r[64:63] != 2'b00) ? jsr_pkg::RES_SAT : sq3_r[62:0];
    acc_sum = {1'b0, acc_r} + {1'b0, sq_sat};
    acc_nxt = acc_sum[63] ? jsr_pkg::RES_SAT : acc_sum[62:0];
  end

  // Control: stage valids, accumulator, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else if (en) begin
      v1_r        <= q_pop;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
      if (v3_r) begin
        acc_r <= done3_r ? '0 : acc_nxt;
      end
    end
  end

  // Payload through the stages
  always_ff @(posedge clk) begin
    if (en) begin
      done1_r   <= q_item.done;
      sum1_r    <= sum_nxt;
      center1_r <= q_item.center;
      row1_r    <= q_item.row;
      col1_r    <= q_item.col;

      done2_r   <= done1_r;
      nv2_r     <= sum1_r[33:2];
      diff2_r   <= diff_nxt;
      row2_r    <= row1_r;
      col2_r    <= col1_r;

      done3_r   <= done2_r;
      nv3_r     <= nv2_r;
      sq3_r     <= prod[64:0];
      row3_r    <= row2_r;
      col3_r    <= col2_r;

      out_done_r <= done3_r;
      if (done3_r) begin
        out_value_r <= '0;
        out_row_r   <= '0;
        out_col_r   <= '0;
        out_res_r   <= acc_r;
      end else begin
        out_value_r <= nv3_r;
        out_row_r   <= row3_r;
        out_col_r   <= col3_r;
        out_res_r   <= '0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.relaxed_value = out_value_r;
  assign out_ch.point_row     = out_row_r;
  assign out_ch.point_column  = out_col_r;
  assign out_ch.residual      = out_res_r;
  assign out_ch.frame_done    = out_done_r;

endmodule

// ===== rtl/jacobi_stencil_residual.sv =====
// Top level: Jacobi five-point relaxation sweep with saturating residual.
//
//  channel  dir  beat payload                                        handshake
//  in_ch    in   sample                                              valid/ready
//  out_ch   out  relaxed_value, point_row, point_column, residual,   valid/ready
//                frame_done
//  cfg_*    in   cfg_index, cfg_wdata (grid_width, grid_height)      cfg_we
//
//  One sample beat per cycle while the queue has room; after the bottom neighbor's
//  beat a result passes the staging, queue, sum, difference, square and result registers.
//  The single-port-read row stores are prefetched one column ahead, which sets
//  the one-beat-per-cycle pace; a geometry write holds in_ch.ready low in the next cycle.
//  Synchronous active-low reset clears position, residual and queue; row stores
//  are not cleared. Back-pressure on out_ch fills the 4-entry queue, then in_ch.ready drops.
module jacobi_stencil_residual #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  jsr_in_if.sink             in_ch,
  jsr_out_if.source          out_ch,
  input  logic               cfg_we,
  input  jsr_pkg::cfg_idx_t  cfg_index,
  input  jsr_pkg::cfg_data_t cfg_wdata
);

  logic               q_push;
  logic               q_pop;
  jsr_pkg::point_t    q_in_item;
  jsr_pkg::point_t    q_out_item;
  jsr_pkg::q_status_t q_st;

  jsr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_st      (q_st),
    .q_push    (q_push),
    .q_item    (q_in_item)
  );

  jsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .status    (q_st)
  );

  jsr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_st   (q_st),
    .q_item (q_out_item),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  // The front never pushes into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_st.full)
    else $error("point pushed into full queue");

  // The back never pops an empty queue
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_st.empty)
    else $error("point popped from empty queue");

  // A geometry write blocks intake for the row-store reload
  a_cfg_reload: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_we && rst_n) |-> !in_ch.ready)
    else $error("sample taken before row-store reload");

endmodule
